### hw/rtl/bmft_pkg.sv
// Shared types and constants for the block-mapped flash translation core.
package bmft_pkg;

  localparam int LBA_W      = 16;
  localparam int PAGE_BITS  = 6;                       // 64 pages per group
  localparam int GRP_W      = LBA_W - PAGE_BITS;
  localparam int MAX_GROUPS = 1 << GRP_W;              // groups an lba can name
  localparam int ADDR_W     = 32;
  localparam int MASK_W     = 1 << PAGE_BITS;
  localparam int ENTRY_W    = ADDR_W + MASK_W;         // {base, written mask}
  localparam int STAT_W     = 2;

  localparam logic [STAT_W-1:0] STAT_READ     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MARKED   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REMAPPED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic init_step;   // write one entry of the clearing pass
    logic load_req;    // capture request, launch table read
    logic exec;        // resolve request, write back, load result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_last;   // clearing pass is at its last entry
    logic out_busy;    // result register holds a result not yet taken
  } sts_t;

endpackage

### hw/rtl/bmft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmft_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/bmft_ctrl.sv
// Sequencing FSM: clearing pass, request accept, execute/write-back.
module bmft_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  bmft_pkg::sts_t sts,
  output bmft_pkg::cmd_t cmd
);
  import bmft_pkg::*;

  typedef enum logic [2:0] {
    S_INIT = 3'b001,
    S_IDLE = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register can take the new result
        if (!sts.out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EXEC))
    else $error("accepted request did not move to execute");

  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !cmd.load_req && !cmd.exec)
    else $error("request handled during clearing pass");

endmodule

### hw/rtl/bmft_dp.sv
// Datapath: mapping table RAM, spare base, request and result registers.
module bmft_dp #(
  parameter int GROUPS      = 1024,
  parameter int BASE_STRIDE = 1000,
  parameter int DEPTH       = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bmft_pkg::cmd_t                cmd,
  output bmft_pkg::sts_t                sts,
  input  logic [bmft_pkg::LBA_W-1:0]    in_tdata,
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bmft_pkg::ADDR_W-1:0]   out_tdata,
  output logic [bmft_pkg::STAT_W-1:0]   out_tuser
);
  import bmft_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [63:0] SPARE_PROD = 64'(GROUPS) * 64'(BASE_STRIDE);
  localparam logic [20:0] GROUPS_W   = 21'(GROUPS);

  // clearing pass
  logic [AW-1:0]     init_addr_r;
  logic [ADDR_W-1:0] init_base_r;

  // captured request
  logic                 op_r;
  logic [PAGE_BITS-1:0] off_r;
  logic                 grp_ok_r;
  logic [AW-1:0]        grp_addr_r;

  logic [ADDR_W-1:0] spare_r, spare_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]    out_phys_r, out_phys_nxt;
  logic [STAT_W-1:0]    out_stat_r, out_stat_nxt;

  logic [GRP_W-1:0]   in_grp;
  logic               in_grp_ok;
  logic [ENTRY_W-1:0] rd_entry;
  logic [ADDR_W-1:0]  rd_base;
  logic [MASK_W-1:0]  rd_mask;
  logic               bit_set;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               exec_we;
  logic [ENTRY_W-1:0] exec_wdata;

  assign in_grp    = in_tdata[LBA_W-1:PAGE_BITS];
  assign in_grp_ok = (21'(in_grp) < GROUPS_W);

  bmft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.load_req),
    .raddr (in_grp[AW-1:0]),
    .rdata (rd_entry)
  );

  assign rd_base = rd_entry[ENTRY_W-1:MASK_W];
  assign rd_mask = rd_entry[MASK_W-1:0];
  assign bit_set = rd_mask[off_r];

  always_comb begin
    exec_we      = 1'b0;
    exec_wdata   = rd_entry;
    spare_nxt    = spare_r;
    out_phys_nxt = out_phys_r;
    out_stat_nxt = out_stat_r;
    if (cmd.exec) begin
      out_phys_nxt = '0;
      if (!grp_ok_r) begin
        out_stat_nxt = STAT_RANGE;
      end else if (!op_r) begin
        out_phys_nxt = rd_base + ADDR_W'(off_r);
        out_stat_nxt = STAT_READ;
      end else if (!bit_set) begin
        exec_we      = 1'b1;
        exec_wdata   = {rd_base, rd_mask | (MASK_W'(1) << off_r)};
        out_stat_nxt = STAT_MARKED;
      end else begin
        // rewrite: trade the group's block for the spare, mask unchanged
        exec_we      = 1'b1;
        exec_wdata   = {spare_r, rd_mask};
        spare_nxt    = rd_base;
        out_stat_nxt = STAT_REMAPPED;
      end
    end
  end

  assign ram_we    = cmd.init_step | exec_we;
  assign ram_waddr = cmd.init_step ? init_addr_r : grp_addr_r;
  assign ram_wdata = cmd.init_step ? {init_base_r, {MASK_W{1'b0}}} : exec_wdata;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_addr_r <= '0;
      init_base_r <= '0;
      spare_r     <= SPARE_PROD[ADDR_W-1:0];
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init_step) begin
        init_addr_r <= init_addr_r + AW'(1);
        init_base_r <= init_base_r + ADDR_W'(BASE_STRIDE);
      end
      spare_r     <= spare_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r       <= in_tuser;
      off_r      <= in_tdata[PAGE_BITS-1:0];
      grp_ok_r   <= in_grp_ok;
      grp_addr_r <= in_grp[AW-1:0];
    end
    out_phys_r <= out_phys_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign sts.init_last = (init_addr_r == AW'(DEPTH - 1));
  assign sts.out_busy  = out_valid_r & ~out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_phys_r;
  assign out_tuser  = out_stat_r;

  a_exec_into_free_reg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid_r && !out_tready))
    else $error("result register overwritten while stalled");

  a_range_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !grp_ok_r) |-> !ram_we)
    else $error("out-of-range request modified the table");

  a_write_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r) |=> (out_tdata == '0))
    else $error("write request returned a nonzero address");

endmodule

### hw/rtl/block_mapped_flash_translation_core.sv
// Flow: an accepted request is captured with its table read, then resolved in the execute
//   state into the result register on out_*; a full result register stalls execution.
// No new request is taken until the last has executed: the one-write, one-read-port RAM
//   reads, then writes back. Reset: synchronous, active low; then, with in_tready low, a
//   clearing pass writes all min(GROUPS, 1024) entries (base = index * stride, mask clear).
// Top level of the block-mapped flash translation core.
module block_mapped_flash_translation_core #(
  parameter int GROUPS      = 1024,
  parameter int BASE_STRIDE = 1000
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bmft_pkg::LBA_W-1:0]    in_tdata,   // [15:0] lba
  input  logic                          in_tuser,   // [0] op
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bmft_pkg::ADDR_W-1:0]   out_tdata,  // [31:0] phys_addr
  output logic [bmft_pkg::STAT_W-1:0]   out_tuser   // [1:0] status
);
  import bmft_pkg::*;

  localparam int DEPTH = (GROUPS < MAX_GROUPS) ? GROUPS : MAX_GROUPS;

  cmd_t cmd;
  sts_t sts;

  bmft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmft_dp #(
    .GROUPS      (GROUPS),
    .BASE_STRIDE (BASE_STRIDE),
    .DEPTH       (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
